// ----- hw/rtl/modular_determinant_core_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef MODULAR_DETERMINANT_CORE_MACROS_SVH
`define MODULAR_DETERMINANT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MDET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MDET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mdet_pkg.sv -----
`timescale 1ns / 1ps

package mdet_pkg;

    // Field widths
    localparam int DATA_W  = 31;
    localparam int ENTRY_W = 32;
    localparam int ORDER_W = 7;

    // Default largest matrix order
    localparam int DEF_MAX_ORDER = 64;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MODULUS = 1'b0;
    localparam t_cfg_idx CFG_ORDER   = 1'b1;

    // Reset values of the registers
    localparam logic [DATA_W-1:0]  RST_MODULUS = DATA_W'(79);
    localparam logic [ORDER_W-1:0] RST_ORDER   = ORDER_W'(1);

endpackage

// ----- hw/rtl/mdet_mulmod.sv -----
`timescale 1ns / 1ps

// Bit-serial modular multiplier: res = (a * b) mod p, MSB of b first.
// Requires a < p. One bit of b per cycle, done pulses after ENTRY_W steps.
module mdet_mulmod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mdet_pkg::DATA_W-1:0]   i_a,
    input  logic [mdet_pkg::ENTRY_W-1:0]  i_b,
    input  logic [mdet_pkg::DATA_W-1:0]   i_p,
    output logic                          o_done,
    output logic [mdet_pkg::DATA_W-1:0]   o_res
);
    import mdet_pkg::*;

    localparam int CNT_W = $clog2(ENTRY_W);

    logic                r_act, n_act;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DATA_W-1:0]   r_a, n_a;
    logic [ENTRY_W-1:0]  r_b, n_b;
    logic [DATA_W-1:0]   r_p, n_p;
    logic [DATA_W-1:0]   r_acc, n_acc;

    logic [DATA_W:0]     dbl;
    logic [DATA_W-1:0]   dbl_red;
    logic [DATA_W:0]     sum;

    // One shift-and-add step with two conditional subtracts
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_p}) ? DATA_W'(dbl - {1'b0, r_p}) : dbl[DATA_W-1:0];
        sum     = {1'b0, dbl_red} + (r_b[ENTRY_W-1] ? {1'b0, r_a} : '0);
        if (sum >= {1'b0, r_p}) begin
            sum = sum - {1'b0, r_p};
        end
    end

    // Sequencing
    always_comb begin
        n_act  = r_act;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_p    = r_p;
        n_acc  = r_acc;
        if (i_start) begin
            n_act = 1'b1;
            n_cnt = '0;
            n_a   = i_a;
            n_b   = i_b;
            n_p   = i_p;
            n_acc = '0;
        end else if (r_act) begin
            n_acc = sum[DATA_W-1:0];
            n_b   = {r_b[ENTRY_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ENTRY_W - 1)) begin
                n_act  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_act  <= n_act;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_p   <= n_p;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// ----- hw/rtl/modular_determinant_core.sv -----
`timescale 1ns / 1ps

// Channel   | Dir | Ports                                  | Transfer
// ----------+-----+----------------------------------------+------------------------------
// entry     | in  | i_start, o_busy, i_entry_value         | i_start high while o_busy low
// result    | out | o_result_valid, o_determinant          | one cycle, o_result_valid high
// config    | in  | i_cfg_we, i_cfg_index, i_cfg_data      | any edge with i_cfg_we high
//
// Each entry is taken in its transfer cycle; the core then waits on the bit-serial
// reduction and writes the reduced entry to the RAM when it completes.
// The last entry of a matrix then runs the elimination out of the single-port matrix RAM,
// with a Fermat inverse of each pivot but the last. o_busy is high throughout.
// Synchronous active-low reset; no clearing pass. The receiver cannot stall results.
module modular_determinant_core #(
    parameter int MAX_ORDER = mdet_pkg::DEF_MAX_ORDER
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [mdet_pkg::ENTRY_W-1:0] i_entry_value,
    output logic                            o_result_valid,
    output logic [mdet_pkg::DATA_W-1:0]     o_determinant,
    input  logic                            i_cfg_we,
    input  mdet_pkg::t_cfg_idx              i_cfg_index,
    input  logic [mdet_pkg::DATA_W-1:0]     i_cfg_data
);
    import mdet_pkg::*;

    localparam int RW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int AW    = 2 * RW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [19:0] {
        ST_IDLE    = 20'b00000000000000000001,
        ST_RED     = 20'b00000000000000000010,
        ST_PIV_RD  = 20'b00000000000000000100,
        ST_PIV_CHK = 20'b00000000000000001000,
        ST_SW_RA   = 20'b00000000000000010000,
        ST_SW_RB   = 20'b00000000000000100000,
        ST_SW_WA   = 20'b00000000000001000000,
        ST_SW_WB   = 20'b00000000000010000000,
        ST_PROD    = 20'b00000000000100000000,
        ST_POW_CHK = 20'b00000000001000000000,
        ST_POW_MUL = 20'b00000000010000000000,
        ST_POW_SQ  = 20'b00000000100000000000,
        ST_EL_RD   = 20'b00000001000000000000,
        ST_EL_CHK  = 20'b00000010000000000000,
        ST_EL_MUL  = 20'b00000100000000000000,
        ST_EL_RI   = 20'b00001000000000000000,
        ST_EL_SM   = 20'b00010000000000000000,
        ST_EL_SW   = 20'b00100000000000000000,
        ST_EL_WR   = 20'b01000000000000000000,
        ST_FIN     = 20'b10000000000000000000
    } t_state;

    t_state               r_state, n_state;
    logic [DATA_W-1:0]    r_modulus, n_modulus;
    logic [ORDER_W-1:0]   r_order, n_order;
    logic [RW-1:0]        r_lr, n_lr, r_lc, n_lc;
    logic [RW-1:0]        r_i, n_i, r_j, n_j, r_k, n_k, r_r, n_r;
    logic                 r_neg, n_neg;
    logic                 r_parity, n_parity;
    logic [DATA_W-1:0]    r_piv, n_piv;
    logic [DATA_W-1:0]    r_prod, n_prod;
    logic [DATA_W-1:0]    r_inv, n_inv;
    logic [DATA_W-1:0]    r_base, n_base;
    logic [DATA_W-1:0]    r_exp, n_exp;
    logic [DATA_W-1:0]    r_tmp, n_tmp;
    logic [DATA_W-1:0]    r_m, n_m;
    logic [DATA_W-1:0]    r_s, n_s;
    logic [DATA_W-1:0]    r_det, n_det;
    logic                 r_out_vld, n_out_vld;

    // Matrix RAM, single port, registered read
    logic [DATA_W-1:0]    r_mem [DEPTH];
    logic [DATA_W-1:0]    r_mem_q;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [DATA_W-1:0]    mem_wdata;

    // Shared multiplier
    logic                 mul_start;
    logic [DATA_W-1:0]    mul_a;
    logic [ENTRY_W-1:0]   mul_b;
    logic                 mul_done;
    logic [DATA_W-1:0]    mul_res;
    logic                 mul_wait;

    // Effective modulus and order
    logic [DATA_W-1:0]    pw;
    logic [RW-1:0]        nm1;
    logic [ENTRY_W-1:0]   ev_u;
    logic [ENTRY_W-1:0]   mag;
    logic [DATA_W-1:0]    red_one;
    logic [DATA_W:0]      sub_w;

    always_comb begin
        int ord_eff;
        ord_eff = int'(r_order);
        if (ord_eff == 0) begin
            ord_eff = 1;
        end
        if (ord_eff > MAX_ORDER) begin
            ord_eff = MAX_ORDER;
        end
        nm1 = RW'(ord_eff - 1);
    end

    assign pw      = (r_modulus == '0) ? DATA_W'(1) : r_modulus;
    assign red_one = (pw == DATA_W'(1)) ? '0 : DATA_W'(1);
    assign ev_u    = i_entry_value;
    assign mag     = ev_u[ENTRY_W-1] ? (ENTRY_W'(0) - ev_u) : ev_u;
    assign sub_w   = {1'b0, r_mem_q} + ((r_mem_q >= r_s) ? '0 : {1'b0, pw}) - {1'b0, r_s};

    mdet_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_p     (pw),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_modulus = r_modulus;
        n_order   = r_order;
        n_lr      = r_lr;
        n_lc      = r_lc;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_r       = r_r;
        n_neg     = r_neg;
        n_parity  = r_parity;
        n_piv     = r_piv;
        n_prod    = r_prod;
        n_inv     = r_inv;
        n_base    = r_base;
        n_exp     = r_exp;
        n_tmp     = r_tmp;
        n_m       = r_m;
        n_s       = r_s;
        n_det     = r_det;
        n_out_vld = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = {r_r, r_i};
        mem_wdata = r_tmp;
        mul_start = 1'b0;
        mul_a     = r_m;
        mul_b     = {1'b0, r_mem_q};

        // register writes restart the load
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS: n_modulus = i_cfg_data;
                CFG_ORDER:   n_order   = i_cfg_data[ORDER_W-1:0];
                default:     n_order   = r_order;
            endcase
            n_lr = '0;
            n_lc = '0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_neg     = ev_u[ENTRY_W-1];
                    mul_start = 1'b1;
                    mul_a     = red_one;
                    mul_b     = mag;
                    n_state   = ST_RED;
                end
            end
            // reduce the entry and store it
            ST_RED: begin
                if (mul_done) begin
                    mem_we    = 1'b1;
                    mem_addr  = {r_lr, r_lc};
                    mem_wdata = (r_neg && mul_res != '0) ? pw - mul_res : mul_res;
                    n_state   = ST_IDLE;
                    if (r_lc == nm1) begin
                        n_lc = '0;
                        if (r_lr == nm1) begin
                            n_lr     = '0;
                            n_prod   = red_one;
                            n_parity = 1'b0;
                            n_i      = '0;
                            n_r      = '0;
                            n_state  = ST_PIV_RD;
                        end else begin
                            n_lr = r_lr + 1'b1;
                        end
                    end else begin
                        n_lc = r_lc + 1'b1;
                    end
                end
            end
            // pivot search down column i
            ST_PIV_RD: begin
                mem_addr = {r_r, r_i};
                n_state  = ST_PIV_CHK;
            end
            ST_PIV_CHK: begin
                if (r_mem_q != '0) begin
                    n_piv = r_mem_q;
                    if (r_r != r_i) begin
                        n_k      = '0;
                        n_parity = ~r_parity;
                        n_state  = ST_SW_RA;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = r_prod;
                        mul_b     = {1'b0, r_mem_q};
                        n_state   = ST_PROD;
                    end
                end else if (r_r == nm1) begin
                    n_det     = '0;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = ST_PIV_RD;
                end
            end
            // row swap, one column at a time: read A, read B, write A, write B
            ST_SW_RA: begin
                mem_addr = {r_i, r_k};
                n_state  = ST_SW_RB;
            end
            ST_SW_RB: begin
                n_tmp    = r_mem_q;
                mem_addr = {r_r, r_k};
                n_state  = ST_SW_WA;
            end
            ST_SW_WA: begin
                mem_we    = 1'b1;
                mem_addr  = {r_i, r_k};
                mem_wdata = r_mem_q;
                n_state   = ST_SW_WB;
            end
            ST_SW_WB: begin
                mem_we    = 1'b1;
                mem_addr  = {r_r, r_k};
                mem_wdata = r_tmp;
                if (r_k == nm1) begin
                    mul_start = 1'b1;
                    mul_a     = r_prod;
                    mul_b     = {1'b0, r_piv};
                    n_state   = ST_PROD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_SW_RA;
                end
            end
            // fold pivot into the product, then invert it unless it is the last pivot
            ST_PROD: begin
                if (mul_done) begin
                    n_prod = mul_res;
                    n_inv  = DATA_W'(1);
                    n_base = r_piv;
                    n_exp  = pw - DATA_W'(2);
                    if (r_i == nm1) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_POW_CHK;
                    end
                end
            end
            // Fermat inverse, exponent bits LSB first
            ST_POW_CHK: begin
                if (r_exp == '0) begin
                    n_j     = r_i + 1'b1;
                    n_state = ST_EL_RD;
                end else if (r_exp[0]) begin
                    mul_start = 1'b1;
                    mul_a     = r_inv;
                    mul_b     = {1'b0, r_base};
                    n_state   = ST_POW_MUL;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = r_base;
                    mul_b     = {1'b0, r_base};
                    n_state   = ST_POW_SQ;
                end
            end
            ST_POW_MUL: begin
                if (mul_done) begin
                    n_inv     = mul_res;
                    mul_start = 1'b1;
                    mul_a     = r_base;
                    mul_b     = {1'b0, r_base};
                    n_state   = ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                if (mul_done) begin
                    n_base  = mul_res;
                    n_exp   = {1'b0, r_exp[DATA_W-1:1]};
                    n_state = ST_POW_CHK;
                end
            end
            // elimination of row j below pivot row i
            ST_EL_RD: begin
                mem_addr = {r_j, r_i};
                n_state  = ST_EL_CHK;
            end
            ST_EL_CHK: begin
                if (r_mem_q == '0) begin
                    if (r_j == nm1) begin
                        n_i     = r_i + 1'b1;
                        n_r     = r_i + 1'b1;
                        n_state = ST_PIV_RD;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_EL_RD;
                    end
                end else begin
                    mul_start = 1'b1;
                    mul_a     = r_mem_q;
                    mul_b     = {1'b0, r_inv};
                    n_state   = ST_EL_MUL;
                end
            end
            ST_EL_MUL: begin
                if (mul_done) begin
                    n_m     = mul_res;
                    n_k     = r_i;
                    n_state = ST_EL_RI;
                end
            end
            ST_EL_RI: begin
                mem_addr = {r_i, r_k};
                n_state  = ST_EL_SM;
            end
            ST_EL_SM: begin
                mul_start = 1'b1;
                mul_a     = r_m;
                mul_b     = {1'b0, r_mem_q};
                n_state   = ST_EL_SW;
            end
            ST_EL_SW: begin
                mem_addr = {r_j, r_k};
                if (mul_done) begin
                    n_s     = mul_res;
                    n_state = ST_EL_WR;
                end
            end
            ST_EL_WR: begin
                mem_we    = 1'b1;
                mem_addr  = {r_j, r_k};
                mem_wdata = sub_w[DATA_W-1:0];
                if (r_k == nm1) begin
                    if (r_j == nm1) begin
                        n_i     = r_i + 1'b1;
                        n_r     = r_i + 1'b1;
                        n_state = ST_PIV_RD;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_EL_RD;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_EL_RI;
                end
            end
            // apply swap sign and emit
            ST_FIN: begin
                if (r_parity && r_prod != '0) begin
                    n_det = pw - r_prod;
                end else begin
                    n_det = r_prod;
                end
                n_out_vld = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Matrix RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_addr];
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_modulus <= RST_MODULUS;
            r_order   <= RST_ORDER;
            r_lr      <= '0;
            r_lc      <= '0;
            r_out_vld <= 1'b0;
            r_parity  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_modulus <= n_modulus;
            r_order   <= n_order;
            r_lr      <= n_lr;
            r_lc      <= n_lc;
            r_out_vld <= n_out_vld;
            r_parity  <= n_parity;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_r    <= n_r;
        r_neg  <= n_neg;
        r_piv  <= n_piv;
        r_prod <= n_prod;
        r_inv  <= n_inv;
        r_base <= n_base;
        r_exp  <= n_exp;
        r_tmp  <= n_tmp;
        r_m    <= n_m;
        r_s    <= n_s;
        r_det  <= n_det;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_determinant  = r_det;

    // States that wait on the multiplier
    assign mul_wait = (r_state == ST_RED) || (r_state == ST_PROD) ||
                      (r_state == ST_POW_MUL) || (r_state == ST_POW_SQ) ||
                      (r_state == ST_EL_MUL) || (r_state == ST_EL_SW);

`include "modular_determinant_core_macros.svh"

    `MDET_ASSERT_NOW(a_det_range, r_out_vld, r_det < pw, "determinant not below modulus")
    `MDET_ASSERT_NEXT(a_busy_after_start, i_start && !o_busy, o_busy, "transfer did not go busy")
    `MDET_ASSERT_NEXT(a_single_result, r_out_vld, !r_out_vld, "result strobe too long")
    `MDET_ASSERT_NOW(a_mul_done_waited, mul_done, mul_wait, "multiplier done outside a wait")

endmodule
